>>> rtl/bff_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the 3x3 box filter.
// Used by bff_front, bff_queue, bff_back and box_filter_three_by_three.
package bff_pkg;

	localparam int MAX_DIM   = 1024;
	localparam int MIN_DIM   = 2;
	localparam int DIM_W     = 11;
	localparam int COORD_W   = 10;
	localparam int CH_W      = 16;
	localparam int PIX_W     = 3 * CH_W;
	localparam int PART_W    = CH_W + 1;
	localparam int FULL_W    = CH_W + 2;
	localparam int SUM_W     = CH_W + 4;
	localparam int RECIP_W   = 23;
	localparam int RECIP_SH  = 24;
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;
	localparam int QCNT_W    = 3;
	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(32);

	// Per-channel column sums: three rows and the lower two rows.
	typedef struct packed {
		logic [2:0][FULL_W-1:0] full;
		logic [2:0][PART_W-1:0] part;
	} col_sum_t;

	typedef struct packed {
		col_sum_t            cur;
		col_sum_t            w1;
		col_sum_t            w2;
		logic [COORD_W-1:0]  row;
		logic [COORD_W-1:0]  col;
		logic                r_ge2;
		logic                c_ge2;
		logic                last_col;
		logic                last_row;
	} item_t;

	typedef enum logic [1:0] {
		RES_UL,
		RES_UR,
		RES_LL,
		RES_LR
	} res_kind_t;

	typedef enum logic [1:0] {
		DIV_4,
		DIV_6,
		DIV_9
	} div_t;

	function automatic logic [RECIP_W-1:0] recip(input div_t d);
		logic [RECIP_W-1:0] m;
		unique case (d)
			DIV_4:   m = RECIP_W'(4194304);
			DIV_6:   m = RECIP_W'(2796203);
			DIV_9:   m = RECIP_W'(1864136);
			default: m = RECIP_W'(4194304);
		endcase
		return m;
	endfunction

endpackage

>>> rtl/box_filter_three_by_three.sv
`timescale 1ns / 1ps
// Top level of the 3x3 box filter: joins bff_front, bff_queue and bff_back.
// Depends on bff_pkg for types and constants.
//
// Pixels enter on the slave stream in raster order of a square image whose side is
// set through cfg_we and cfg_data (clamped to 2..1024; reset value 32). A write
// restarts the position at row 0, column 0; the user must make it only while the
// block is idle, as the block does not enforce this. Each pixel beat completes from
// zero to four smoothed pixels, which leave on the master stream with row and column;
// tlast marks the last beat caused by one input pixel and tuser marks the last beat of
// the image. The last row leaves together with the row above it.
// One pixel is taken every cycle; the back end gives one result per cycle while the
// receiver is ready, so pixels at the last column or on the last row, which give two
// to four results, hold the input for the extra cycles once the four-entry work queue
// is full. The line memory is read on input and written back when the pixel moves on,
// the next cycle unless the queue is full; a read and a write in the same cycle are
// always on different columns, so it needs one port of each kind.
// Reset empties the pipeline and the queue; line memory contents are not cleared and
// are never used before they are written in the current image. When the receiver
// stalls, the output register holds its beat and the back end stops; the front keeps
// taking pixels until the queue fills.
module box_filter_three_by_three (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bff_pkg::DIM_W-1:0]      cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bff_pkg::PIX_W-1:0]      s_tdata,   // in_red, in_green, in_blue
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [71:0]                    m_tdata,   // out_row, out_col, out_red,
	                                                  // out_green, out_blue, zero pad
	output logic                           m_tlast,
	output logic                           m_tuser    // frame_done
);

	logic                                q_full;
	logic                                q_push;
	bff_pkg::item_t                      q_push_item;
	logic                                q_pop;
	logic                                q_not_empty;
	bff_pkg::item_t                      q_head;
	logic [bff_pkg::COORD_W-1:0]         row_out;
	logic [bff_pkg::COORD_W-1:0]         col_out;
	logic [2:0][bff_pkg::CH_W-1:0]       mean_out;

	bff_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.push      (q_push),
		.push_item (q_push_item)
	);

	bff_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	bff_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (q_head),
		.pop         (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.row_out     (row_out),
		.col_out     (col_out),
		.mean_out    (mean_out),
		.run_last    (m_tlast),
		.frame_done  (m_tuser)
	);

	assign m_tdata = {4'b0000, mean_out[2], mean_out[1], mean_out[0], col_out, row_out};

endmodule

>>> rtl/bff_front.sv
`timescale 1ns / 1ps
// Front part of the box filter: takes pixels, tracks the raster position, keeps the
// line memory and the column-sum window, and pushes work items. Uses bff_pkg.
module bff_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bff_pkg::DIM_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bff_pkg::PIX_W-1:0]     s_tdata,
	input  logic                          q_full,
	output logic                          push,
	output bff_pkg::item_t                push_item
);

	logic [bff_pkg::DIM_W-1:0]   dim_q;
	logic [bff_pkg::COORD_W-1:0] row_q;
	logic [bff_pkg::COORD_W-1:0] col_q;
	logic                        last_col;
	logic                        last_row;
	logic                        accept;

	logic                        valid_s1;
	logic [bff_pkg::PIX_W-1:0]   pix_s1;
	logic [2*bff_pkg::PIX_W-1:0] rd_s1;
	logic [bff_pkg::COORD_W-1:0] row_s1;
	logic [bff_pkg::COORD_W-1:0] col_s1;
	logic                        last_col_s1;
	logic                        last_row_s1;

	logic [2*bff_pkg::PIX_W-1:0] line_mem [bff_pkg::MAX_DIM];
	bff_pkg::col_sum_t           w1_q;
	bff_pkg::col_sum_t           w2_q;
	bff_pkg::col_sum_t           cur;
	logic [bff_pkg::PIX_W-1:0]   top;
	logic [bff_pkg::PIX_W-1:0]   mid;
	logic                        need_push;
	logic                        advance;

	assign last_col = ({1'b0, col_q} == dim_q - bff_pkg::DIM_W'(1));
	assign last_row = ({1'b0, row_q} == dim_q - bff_pkg::DIM_W'(1));
	assign accept   = s_tvalid && s_tready;

	assign top = rd_s1[2*bff_pkg::PIX_W-1:bff_pkg::PIX_W];
	assign mid = rd_s1[bff_pkg::PIX_W-1:0];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cur.part[k] = bff_pkg::PART_W'(mid[k*bff_pkg::CH_W +: bff_pkg::CH_W])
				+ bff_pkg::PART_W'(pix_s1[k*bff_pkg::CH_W +: bff_pkg::CH_W]);
			cur.full[k] = bff_pkg::FULL_W'(top[k*bff_pkg::CH_W +: bff_pkg::CH_W])
				+ bff_pkg::FULL_W'(cur.part[k]);
		end
	end

	assign need_push = (row_s1 != '0) && (col_s1 != '0);
	assign advance   = valid_s1 && (!need_push || !q_full);
	assign s_tready  = !valid_s1 || !need_push || !q_full;
	assign push      = advance && need_push;

	always_comb begin
		push_item.cur      = cur;
		push_item.w1       = w1_q;
		push_item.w2       = w2_q;
		push_item.row      = row_s1;
		push_item.col      = col_s1;
		push_item.r_ge2    = (row_s1 >= bff_pkg::COORD_W'(2));
		push_item.c_ge2    = (col_s1 >= bff_pkg::COORD_W'(2));
		push_item.last_col = last_col_s1;
		push_item.last_row = last_row_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q    <= bff_pkg::DIM_RESET;
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				priority if (cfg_data < bff_pkg::DIM_W'(bff_pkg::MIN_DIM)) begin
					dim_q <= bff_pkg::DIM_W'(bff_pkg::MIN_DIM);
				end else if (cfg_data > bff_pkg::DIM_W'(bff_pkg::MAX_DIM)) begin
					dim_q <= bff_pkg::DIM_W'(bff_pkg::MAX_DIM);
				end else begin
					dim_q <= cfg_data;
				end
				row_q <= '0;
				col_q <= '0;
			end else if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + bff_pkg::COORD_W'(1);
				end else begin
					col_q <= col_q + bff_pkg::COORD_W'(1);
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= s_tdata;
			row_s1      <= row_q;
			col_s1      <= col_q;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
			rd_s1       <= line_mem[col_q];
		end
		if (advance) begin
			line_mem[col_s1] <= {mid, pix_s1};
			w1_q             <= cur;
			w2_q             <= w1_q;
		end
	end

endmodule

>>> rtl/bff_queue.sv
`timescale 1ns / 1ps
// Short queue of work items between the front and back parts of the box filter.
// Uses bff_pkg for the item type and depth.
module bff_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bff_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output bff_pkg::item_t head
);

	bff_pkg::item_t             entries_q [bff_pkg::QDEPTH];
	logic [bff_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [bff_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [bff_pkg::QCNT_W-1:0] count_q;

	assign full      = (count_q == bff_pkg::QCNT_W'(bff_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + bff_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bff_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + bff_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - bff_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/bff_back.sv
`timescale 1ns / 1ps
// Back part of the box filter: walks the results of each work item, adds the
// column sums and divides by 4, 6 or 9 through a reciprocal multiply. Uses bff_pkg.
module bff_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_not_empty,
	input  bff_pkg::item_t                  head,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bff_pkg::COORD_W-1:0]     row_out,
	output logic [bff_pkg::COORD_W-1:0]     col_out,
	output logic [2:0][bff_pkg::CH_W-1:0]   mean_out,
	output logic                            run_last,
	output logic                            frame_done
);

	bff_pkg::res_kind_t kind_q;
	bff_pkg::res_kind_t kind_d;
	bff_pkg::res_kind_t next_kind;
	logic               is_last;
	logic               en;
	logic               take;
	logic               use_full;
	logic               three_cols;
	bff_pkg::div_t      div_sel;
	logic [bff_pkg::COORD_W-1:0] row_res;
	logic [bff_pkg::COORD_W-1:0] col_res;
	logic [2:0][bff_pkg::SUM_W-1:0] sum;

	logic                              valid_s1;
	logic [2:0][bff_pkg::SUM_W-1:0]    sum_s1;
	bff_pkg::div_t                     div_s1;
	logic [bff_pkg::COORD_W-1:0]       row_s1;
	logic [bff_pkg::COORD_W-1:0]       col_s1;
	logic                              run_last_s1;
	logic                              frame_done_s1;
	logic [bff_pkg::RECIP_W-1:0]       recip_s1;
	logic [2:0][bff_pkg::PROD_W-1:0]   prod;

	logic                              valid_s2;
	logic [2:0][bff_pkg::CH_W-1:0]     mean_s2;
	logic [bff_pkg::COORD_W-1:0]       row_s2;
	logic [bff_pkg::COORD_W-1:0]       col_s2;
	logic                              run_last_s2;
	logic                              frame_done_s2;

	assign en   = !valid_s2 || m_tready;
	assign take = en && q_not_empty;
	assign pop  = take && is_last;

	always_comb begin
		next_kind = bff_pkg::RES_UL;
		is_last   = 1'b1;
		unique case (kind_q)
			bff_pkg::RES_UL: begin
				priority if (head.last_col) begin
					next_kind = bff_pkg::RES_UR;
					is_last   = 1'b0;
				end else if (head.last_row) begin
					next_kind = bff_pkg::RES_LL;
					is_last   = 1'b0;
				end
			end
			bff_pkg::RES_UR: begin
				if (head.last_row) begin
					next_kind = bff_pkg::RES_LL;
					is_last   = 1'b0;
				end
			end
			bff_pkg::RES_LL: begin
				if (head.last_col) begin
					next_kind = bff_pkg::RES_LR;
					is_last   = 1'b0;
				end
			end
			bff_pkg::RES_LR: begin
				is_last = 1'b1;
			end
			default: begin
				is_last = 1'b1;
			end
		endcase
	end

	always_comb begin
		kind_d = kind_q;
		if (take) begin
			kind_d = is_last ? bff_pkg::RES_UL : next_kind;
		end
	end

	always_comb begin
		use_full   = 1'b0;
		three_cols = 1'b0;
		row_res    = head.row;
		col_res    = head.col;
		unique case (kind_q)
			bff_pkg::RES_UL: begin
				use_full   = head.r_ge2;
				three_cols = head.c_ge2;
				row_res    = head.row - bff_pkg::COORD_W'(1);
				col_res    = head.col - bff_pkg::COORD_W'(1);
			end
			bff_pkg::RES_UR: begin
				use_full = head.r_ge2;
				row_res  = head.row - bff_pkg::COORD_W'(1);
			end
			bff_pkg::RES_LL: begin
				three_cols = head.c_ge2;
				col_res    = head.col - bff_pkg::COORD_W'(1);
			end
			bff_pkg::RES_LR: begin
				use_full = 1'b0;
			end
			default: begin
				use_full = 1'b0;
			end
		endcase
		if (use_full && three_cols) begin
			div_sel = bff_pkg::DIV_9;
		end else if (use_full || three_cols) begin
			div_sel = bff_pkg::DIV_6;
		end else begin
			div_sel = bff_pkg::DIV_4;
		end
		for (int k = 0; k < 3; k++) begin
			if (use_full) begin
				sum[k] = bff_pkg::SUM_W'(head.cur.full[k]) + bff_pkg::SUM_W'(head.w1.full[k])
					+ (three_cols ? bff_pkg::SUM_W'(head.w2.full[k]) : '0);
			end else begin
				sum[k] = bff_pkg::SUM_W'(head.cur.part[k]) + bff_pkg::SUM_W'(head.w1.part[k])
					+ (three_cols ? bff_pkg::SUM_W'(head.w2.part[k]) : '0);
			end
		end
	end

	assign recip_s1 = bff_pkg::recip(div_s1);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k] = bff_pkg::PROD_W'(sum_s1[k]) * bff_pkg::PROD_W'(recip_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= bff_pkg::RES_UL;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			kind_q <= kind_d;
			if (en) begin
				valid_s1 <= q_not_empty;
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1        <= sum;
			div_s1        <= div_sel;
			row_s1        <= row_res;
			col_s1        <= col_res;
			run_last_s1   <= is_last;
			frame_done_s1 <= is_last && head.last_row && head.last_col;
			for (int k = 0; k < 3; k++) begin
				mean_s2[k] <= prod[k][bff_pkg::RECIP_SH +: bff_pkg::CH_W];
			end
			row_s2        <= row_s1;
			col_s2        <= col_s1;
			run_last_s2   <= run_last_s1;
			frame_done_s2 <= frame_done_s1;
		end
	end

	assign m_tvalid   = valid_s2;
	assign row_out    = row_s2;
	assign col_out    = col_s2;
	assign mean_out   = mean_s2;
	assign run_last   = run_last_s2;
	assign frame_done = frame_done_s2;

endmodule
